>>> sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by the controller, the datapath and the top level.
package spq_pkg;

  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int FILL_W = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

>>> sv/spq_ctrl.sv
// Request sequencer: accept, execute, hold result until transferred.
// Depends on spq_pkg; drives the datapath command struct.
module spq_ctrl import spq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign cmd.load  = (state == S_IDLE) && in_valid;
  assign cmd.exec  = (state == S_EXEC);

endmodule

>>> sv/spq_datapath.sv
// Entry cells with parallel compare and one-place shift, count and result registers.
// Depends on spq_pkg; sequenced by spq_ctrl through dp_cmd_t.
module spq_datapath import spq_pkg::*; #(
  parameter int DEPTH      = 8,
  parameter int PRIO_WIDTH = 16,
  parameter int TAG_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  input  logic [REQ_W-1:0]             req_type,
  input  logic signed [PRIO_WIDTH-1:0] prio,
  input  logic [TAG_WIDTH-1:0]         tag,
  output logic [STAT_W-1:0]            status,
  output logic signed [PRIO_WIDTH-1:0] out_prio,
  output logic [TAG_WIDTH-1:0]         out_tag,
  output logic [FILL_W-1:0]            fill_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [REQ_W-1:0]             req_q;
  logic signed [PRIO_WIDTH-1:0] prio_q;
  logic [TAG_WIDTH-1:0]         tag_q;
  logic [CNT_W-1:0]             count;

  logic signed [PRIO_WIDTH-1:0] cell_prio [DEPTH];
  logic [TAG_WIDTH-1:0]         cell_tag  [DEPTH];
  logic signed [PRIO_WIDTH-1:0] prio_next [DEPTH];
  logic [TAG_WIDTH-1:0]         tag_next  [DEPTH];
  logic signed [PRIO_WIDTH-1:0] up_prio   [DEPTH];
  logic [TAG_WIDTH-1:0]         up_tag    [DEPTH];
  logic signed [PRIO_WIDTH-1:0] dn_prio   [DEPTH];
  logic [TAG_WIDTH-1:0]         dn_tag    [DEPTH];

  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] ge_ext;
  logic             full;
  logic             empty;
  logic             ins_ok;
  logic             rem_ok;

  stat_t                        status_r;
  logic signed [PRIO_WIDTH-1:0] out_prio_r;
  logic [TAG_WIDTH-1:0]         out_tag_r;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign ins_ok = (req_q == REQ_INSERT) && !full;
  assign rem_ok = (req_q == REQ_REMOVE) && !empty;
  assign ge_ext = {ge[DEPTH-2:0], 1'b1};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ge[i] = (CNT_W'(i) < count) && (cell_prio[i] >= prio_q);

    if (i == 0) begin : g_head
      assign up_prio[i] = prio_q;
      assign up_tag[i]  = tag_q;
    end else begin : g_body
      assign up_prio[i] = cell_prio[i-1];
      assign up_tag[i]  = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign dn_prio[i] = cell_prio[i];
      assign dn_tag[i]  = cell_tag[i];
    end else begin : g_inner
      assign dn_prio[i] = cell_prio[i+1];
      assign dn_tag[i]  = cell_tag[i+1];
    end

    always_comb begin
      prio_next[i] = cell_prio[i];
      tag_next[i]  = cell_tag[i];
      if (ins_ok && !ge[i]) begin
        if (ge_ext[i]) begin
          prio_next[i] = prio_q;
          tag_next[i]  = tag_q;
        end else begin
          prio_next[i] = up_prio[i];
          tag_next[i]  = up_tag[i];
        end
      end else if (rem_ok) begin
        prio_next[i] = dn_prio[i];
        tag_next[i]  = dn_tag[i];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        cell_prio[i] <= prio_next[i];
        cell_tag[i]  <= tag_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      prio_q <= prio;
      tag_q  <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      if (ins_ok) begin
        count <= count + CNT_W'(1);
      end else if (rem_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r   <= ST_OK;
      out_prio_r <= '0;
      out_tag_r  <= '0;
      unique case (req_q)
        REQ_INSERT: begin
          if (full) status_r <= ST_FULL;
        end
        REQ_REMOVE, REQ_PEEK: begin
          if (empty) begin
            status_r <= ST_EMPTY;
          end else begin
            out_prio_r <= cell_prio[0];
            out_tag_r  <= cell_tag[0];
          end
        end
        default: begin
          status_r <= ST_OK;
        end
      endcase
    end
  end

  assign status     = status_r;
  assign out_prio   = out_prio_r;
  assign out_tag    = out_tag_r;
  assign fill_count = FILL_W'(count);

endmodule

>>> sv/sorted_priority_queue.sv
// Sorted priority queue, highest priority at the head, equal priorities in arrival order.
// Result is registered in the execute state and presented in the done state; a new request
// is taken only once the result is transferred (accept / execute / deliver sequence).
// All cells compare and shift together in the execute state.
// Reset clears the entry count and the controller; entry contents stay undefined.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH      = 8,
  parameter int PRIO_WIDTH = 16,
  parameter int TAG_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [REQ_W-1:0]             req_type,
  input  logic signed [PRIO_WIDTH-1:0] prio,
  input  logic [TAG_WIDTH-1:0]         tag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [STAT_W-1:0]            status,
  output logic signed [PRIO_WIDTH-1:0] out_prio,
  output logic [TAG_WIDTH-1:0]         out_tag,
  output logic [FILL_W-1:0]            fill_count
);

  dp_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH      (DEPTH),
    .PRIO_WIDTH (PRIO_WIDTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .prio       (prio),
    .tag        (tag),
    .status     (status),
    .out_prio   (out_prio),
    .out_tag    (out_tag),
    .fill_count (fill_count)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> ##1 out_valid)
    else $error("result not presented two cycles after transfer");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> fill_count == FILL_W'(DEPTH))
    else $error("full status with queue not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> fill_count == '0)
    else $error("empty status with entries stored");

endmodule
